[sv/srpg_pkg.sv]
`default_nettype none

package srpg_pkg;

   // Register reset values
   localparam logic [7:0] MIN_PERIOD_RESET  = 8'd10;
   localparam logic [7:0] RAMP_LENGTH_RESET = 8'd50;

   // Defaults for the top-level parameters
   localparam int TOGGLES_PER_STEP_DEF = 4;
   localparam int STEP_WIDTH_DEF       = 14;

   // Fixed field widths
   localparam int PERIOD_W     = 9;
   localparam int PULSES_W     = 16;
   localparam int TOGGLE_W     = 4;
   localparam int STEPS_LEFT_W = 14;
   localparam int STEP_CNT_W   = 15;
   localparam int PRODUCT_W    = 20;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 24;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 8;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_PERIOD  = 1'b0,
      CSR_RAMP_LENGTH = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

[sv/stepper_ramp_pulse_generator_unit.sv]
// Stepper ramp pulse generator with a trapezoidal speed profile.
//
// Input channel (req_): req_tuser selects the item kind, 0 = timer tick,
// 1 = move command; req_tdata[14:0] carries the signed step count of a move.
// Each item, tick or command, produces exactly one result item on rsp_ with
// the step pin level, direction, whole steps left and a busy flag, all taken
// after the item's update.
// Configuration (csr_): index 0 = min_period, index 1 = ramp_length, 8-bit
// data; csr_ready is always high. Write only while no items are in flight.
//
// The result is registered: rsp_tvalid rises in the cycle after acceptance.
// Throughput: one item per cycle while rsp_tready drains the result register;
// the whole update is one pass of compare/add logic from state to result regs.
// Stall: the result register holds while rsp_tready is low; a new item is
// still taken when the register is being emptied in the same cycle, so
// req_tready = !rsp_tvalid || rsp_tready.
// Reset (synchronous, active high): all motion state clears, min_period
// returns to 10 and ramp_length to 50, the result register empties.
`default_nettype none

module stepper_ramp_pulse_generator_unit #(
   parameter int TOGGLES_PER_STEP = srpg_pkg::TOGGLES_PER_STEP_DEF,
   parameter int STEP_WIDTH       = srpg_pkg::STEP_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [14:0] step_count (signed), [15] zero fill
   input  wire logic [srpg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] cmd
   input  wire logic                               req_tuser,
   // result channel
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [0] step_pin, [1] dir_pin, [15:2] steps_left, [16] busy_res, [23:17] zero
   output      logic [srpg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration write channel
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [srpg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [srpg_pkg::CSR_DATA_W-1:0]    csr_data
);

   import srpg_pkg::*;

   localparam int SW = STEP_WIDTH;
   localparam logic [SW:0] STEP_MAX = (SW+1)'((64'd1 << SW) - 64'd1);

   // Configuration registers
   logic [7:0] min_period_ff;
   logic [7:0] ramp_length_ff;

   // Motion state
   logic [PERIOD_W-1:0] tick_count_ff,      tick_count_in;
   logic [PULSES_W-1:0] pulses_left_ff,     pulses_left_in;
   logic [TOGGLE_W-1:0] toggle_count_ff,    toggle_count_in;
   logic [SW-1:0]       steps_remaining_ff, steps_remaining_in;
   logic [SW-1:0]       steps_total_ff,     steps_total_in;
   logic                step_level_ff,      step_level_in;
   logic                direction_ff,       direction_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;

   logic                  req_accept;

   // Command decode
   logic [STEP_CNT_W-1:0] raw_count;
   logic                  neg;
   logic [15:0]           mag_full;
   logic [SW-1:0]         mag_sat;
   logic [PRODUCT_W-1:0]  pulse_product;
   logic [PULSES_W-1:0]   pulses_sat;

   // Tick decode
   logic [SW-1:0]       ramp_ext;
   logic [SW-1:0]       steps_done;
   logic [7:0]          ramp_extra;
   logic [PERIOD_W-1:0] period;
   logic [PERIOD_W-1:0] tick_next;
   logic                toggle_event;
   logic [TOGGLE_W-1:0] toggle_step;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Move command: magnitude, saturation and pulse count
   always_comb begin
      raw_count = req_tdata[STEP_CNT_W-1:0];
      neg       = raw_count[STEP_CNT_W-1];
      mag_full  = neg ? (16'h8000 - {1'b0, raw_count}) : {1'b0, raw_count};
      if (PRODUCT_W'(mag_full) > PRODUCT_W'(STEP_MAX)) begin
         mag_sat = STEP_MAX[SW-1:0];
      end else begin
         mag_sat = SW'(mag_full);
      end
      pulse_product = PRODUCT_W'(mag_sat) * PRODUCT_W'(TOGGLES_PER_STEP);
      if (pulse_product > PRODUCT_W'(16'hFFFF)) begin
         pulses_sat = 16'hFFFF;
      end else begin
         pulses_sat = pulse_product[PULSES_W-1:0];
      end
   end

   // Tick period from the linear ramp, then the tick counter compare
   always_comb begin
      ramp_ext   = SW'(ramp_length_ff);
      steps_done = (steps_total_ff >= steps_remaining_ff) ?
                   (steps_total_ff - steps_remaining_ff) : '0;
      if (steps_remaining_ff <= ramp_ext) begin
         // decelerating near the end of the move
         ramp_extra = ramp_length_ff - steps_remaining_ff[7:0];
      end else if (steps_done < ramp_ext) begin
         // accelerating at the start of the move
         ramp_extra = ramp_length_ff - steps_done[7:0];
      end else begin
         ramp_extra = 8'd0;
      end
      period = {1'b0, min_period_ff} + {1'b0, ramp_extra};

      // saturate the counter at its top value
      tick_next    = (&tick_count_ff) ? tick_count_ff : tick_count_ff + 1'b1;
      toggle_event = (tick_next >= period);
   end

   // Next state for one accepted item
   always_comb begin
      tick_count_in      = tick_count_ff;
      pulses_left_in     = pulses_left_ff;
      toggle_count_in    = toggle_count_ff;
      steps_remaining_in = steps_remaining_ff;
      steps_total_in     = steps_total_ff;
      step_level_in      = step_level_ff;
      direction_in       = direction_ff;
      toggle_step        = toggle_count_ff;

      if (req_tuser) begin
         // load a new move; keep tick counter and pin level
         direction_in       = !neg && (raw_count != '0);
         pulses_left_in     = pulses_sat;
         steps_remaining_in = mag_sat;
         steps_total_in     = mag_sat;
         toggle_count_in    = '0;
      end else if (toggle_event) begin
         if (pulses_left_ff != '0) begin
            step_level_in  = !step_level_ff;
            pulses_left_in = pulses_left_ff - 1'b1;
            toggle_step    = toggle_count_ff + 1'b1;
         end
         // check the toggle count on every event, even an idle one
         if (toggle_step >= TOGGLE_W'(TOGGLES_PER_STEP)) begin
            toggle_count_in = '0;
            if (steps_remaining_ff != '0) begin
               steps_remaining_in = steps_remaining_ff - 1'b1;
            end
         end else begin
            toggle_count_in = toggle_step;
         end
         tick_count_in = '0;
      end else begin
         tick_count_in = tick_next;
      end
   end

   // Result register: fill on accept, drain on rsp handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_data_in = {7'd0,
                     pulses_left_in != '0,
                     STEPS_LEFT_W'(steps_remaining_in),
                     direction_in,
                     step_level_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff  <= MIN_PERIOD_RESET;
         ramp_length_ff <= RAMP_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_PERIOD:  min_period_ff  <= csr_data;
            CSR_RAMP_LENGTH: ramp_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff      <= '0;
         pulses_left_ff     <= '0;
         toggle_count_ff    <= '0;
         steps_remaining_ff <= '0;
         steps_total_ff     <= '0;
         step_level_ff      <= 1'b0;
         direction_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            tick_count_ff      <= tick_count_in;
            pulses_left_ff     <= pulses_left_in;
            toggle_count_ff    <= toggle_count_in;
            steps_remaining_ff <= steps_remaining_in;
            steps_total_ff     <= steps_total_in;
            step_level_ff      <= step_level_in;
            direction_ff       <= direction_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // An accepted item always shows up as a result in the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // Remaining steps never exceed the move's total
   a_remaining_in_total: assert property (@(posedge clock) disable iff (reset)
      steps_remaining_ff <= steps_total_ff)
      else $error("steps remaining above steps total");

   // Toggle counter wraps before reaching a whole step
   a_toggle_below_step: assert property (@(posedge clock) disable iff (reset)
      toggle_count_ff < TOGGLE_W'(TOGGLES_PER_STEP))
      else $error("toggle count reached a whole step without wrapping");

   // Busy flag in the result matches the pulse counter it was taken from
   a_busy_matches: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_data_ff[16] == (pulses_left_ff != '0)))
      else $error("busy flag disagrees with pulse counter");

endmodule

`default_nettype wire

[sim/tb_stepper_ramp_pulse_generator_unit.sv]
module tb_stepper_ramp_pulse_generator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import srpg_pkg::*;

   // Kind of item on the request channel, carried in req_tuser
   typedef enum logic {
      ITEM_TICK = 1'b0,
      ITEM_MOVE = 1'b1
   } item_kind_type;

   // One status item as the block reports it after each request
   typedef struct packed {
      logic                    busy;
      logic [STEPS_LEFT_W-1:0] steps_left;
      logic                    dir_pin;
      logic                    step_pin;
   } motion_status_type;

   localparam int STEP_LIMIT     = (1 << STEP_WIDTH_DEF) - 1;
   localparam int PULSE_LIMIT    = (1 << PULSES_W) - 1;
   localparam int TICK_LIMIT     = (1 << PERIOD_W) - 1;
   localparam int LONG_HOLD      = 80;
   localparam int DRAIN_BOUND    = 5000;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int REPORT_LIMIT   = 10;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid;
   logic                    csr_ready;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   // Motion state mirrored from the block, at the block's widths
   logic [CSR_DATA_W-1:0]   min_period_q = MIN_PERIOD_RESET;
   logic [CSR_DATA_W-1:0]   ramp_q       = RAMP_LENGTH_RESET;
   logic [PERIOD_W-1:0]     tick_q       = '0;
   logic [PULSES_W-1:0]     pulses_q     = '0;
   logic [TOGGLE_W-1:0]     toggles_q    = '0;
   logic [STEPS_LEFT_W-1:0] remaining_q  = '0;
   logic [STEPS_LEFT_W-1:0] total_q      = '0;
   logic                    level_q      = 1'b0;
   logic                    direction_q  = 1'b0;

   motion_status_type pending_status[$];

   int  mismatch_count    = 0;
   int  items_sent        = 0;
   bit  req_steady        = 1'b0;
   bit  rsp_steady        = 1'b0;
   bit  long_hold_pending = 1'b0;

   stepper_ramp_pulse_generator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Idle length for either side: mostly none or short, now and then long
   function automatic int pick_gap(input bit steady);
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 25);
   endfunction

   // Apply one accepted item to the mirrored state and queue the status it yields
   task automatic advance_motion(input item_kind_type kind,
                                 input logic [STEP_CNT_W-1:0] count);
      int                magnitude;
      int                period;
      int                travelled;
      int                remaining;
      int                total;
      int                ticks;
      motion_status_type status;
      if (kind == ITEM_MOVE) begin
         // negative counts take their two's complement magnitude, then clamp
         magnitude = count[STEP_CNT_W-1] ? (1 << STEP_CNT_W) - int'(count) : int'(count);
         if (magnitude > STEP_LIMIT) begin
            magnitude = STEP_LIMIT;
         end
         direction_q = !count[STEP_CNT_W-1] && (count != '0);
         if (magnitude * TOGGLES_PER_STEP_DEF > PULSE_LIMIT) begin
            pulses_q = PULSE_LIMIT[PULSES_W-1:0];
         end else begin
            pulses_q = PULSES_W'(magnitude * TOGGLES_PER_STEP_DEF);
         end
         remaining_q = STEPS_LEFT_W'(magnitude);
         total_q     = STEPS_LEFT_W'(magnitude);
         // a new move restarts the toggle count; tick counter and pin level stay
         toggles_q   = '0;
      end else begin
         remaining = int'(remaining_q);
         total     = int'(total_q);
         if (remaining <= int'(ramp_q)) begin
            // slowing down toward the end of the move
            period = int'(min_period_q) + int'(ramp_q) - remaining;
         end else begin
            travelled = (total >= remaining) ? total - remaining : 0;
            if (travelled < int'(ramp_q)) begin
               period = int'(min_period_q) + int'(ramp_q) - travelled;
            end else begin
               period = int'(min_period_q);
            end
         end
         ticks = int'(tick_q);
         if (ticks < TICK_LIMIT) begin
            ticks++;
         end
         if (ticks >= period) begin
            if (pulses_q != '0) begin
               level_q = ~level_q;
               pulses_q--;
               toggles_q++;
            end
            if (int'(toggles_q) >= TOGGLES_PER_STEP_DEF) begin
               toggles_q = '0;
               if (remaining_q != '0) begin
                  remaining_q--;
               end
            end
            ticks = 0;
         end
         tick_q = PERIOD_W'(ticks);
      end
      status.step_pin   = level_q;
      status.dir_pin    = direction_q;
      status.steps_left = remaining_q;
      status.busy       = (pulses_q != '0);
      pending_status.push_back(status);
   endtask

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
      end
   endtask

   // Offer one item after a random gap; entered and left at a falling edge
   task automatic send_item(input item_kind_type kind, input logic [STEP_CNT_W-1:0] count);
      int gap;
      gap = pick_gap(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, count};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      advance_motion(kind, count);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(ITEM_TICK, STEP_CNT_W'($urandom));
   endtask

   // Drop valid and wait until every queued status has come back
   task automatic drain_results();
      int waited;
      req_tvalid <= 1'b0;
      for (waited = 0; pending_status.size() > 0 && waited < DRAIN_BOUND; waited++) begin
         @(negedge clock);
      end
      if (pending_status.size() > 0) begin
         flag_mismatch("missing result items", 0, pending_status.size());
         pending_status.delete();
      end
      // margin after the last result
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (index == CSR_MIN_PERIOD) begin
         min_period_q = value;
      end else begin
         ramp_q = value;
      end
      @(negedge clock);
   endtask

   // Only called with the block idle
   task automatic set_profile(input int min_period, input int ramp_length);
      write_csr(CSR_MIN_PERIOD, CSR_DATA_W'(min_period));
      write_csr(CSR_RAMP_LENGTH, CSR_DATA_W'(ramp_length));
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver: random stalls, and one long hold-off when asked for
   initial begin
      int stall;
      int hold_count;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) begin
               @(negedge clock);
            end
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_gap(rsp_steady);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each accepted status item with the oldest one predicted
   always @(posedge clock) begin
      motion_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            flag_mismatch("unexpected result item", 0, int'(rsp_tdata));
         end else begin
            want = pending_status.pop_front();
            if (rsp_tdata[0] !== want.step_pin) begin
               flag_mismatch("step_pin", int'(want.step_pin), int'(rsp_tdata[0]));
            end
            if (rsp_tdata[1] !== want.dir_pin) begin
               flag_mismatch("dir_pin", int'(want.dir_pin), int'(rsp_tdata[1]));
            end
            if (rsp_tdata[15:2] !== want.steps_left) begin
               flag_mismatch("steps_left", int'(want.steps_left), int'(rsp_tdata[15:2]));
            end
            if (rsp_tdata[16] !== want.busy) begin
               flag_mismatch("busy_res", int'(want.busy), int'(rsp_tdata[16]));
            end
            if (rsp_tdata[RSP_DATA_W-1:17] !== '0) begin
               flag_mismatch("zero fill", 0, int'(rsp_tdata[RSP_DATA_W-1:17]));
            end
         end
      end
   end

   // Ticks straight out of reset: default profile, nothing to move
   task automatic test_reset_state();
      send_ticks(2);
   endtask

   // Move commands at the limits of the step count, including zero,
   // the most negative count (clamped magnitude) and minus one
   task automatic test_move_extremes();
      send_item(ITEM_MOVE, 15'h0000);
      send_item(ITEM_MOVE, 15'h3FFF);
      send_ticks(1);
      send_item(ITEM_MOVE, 15'h4001);
      send_item(ITEM_MOVE, 15'h4000);
      send_ticks(1);
      send_item(ITEM_MOVE, 15'h7FFF);
      send_item(ITEM_MOVE, 15'h0001);
      send_ticks(1);
      drain_results();
   endtask

   // Zero period toggles on every tick; a second move arrives mid-step and
   // must restart the toggle count, then ticks run on past the last pulse
   task automatic test_zero_period_restart();
      set_profile(0, 0);
      send_item(ITEM_MOVE, 15'd2);
      send_ticks(3);
      send_item(ITEM_MOVE, 15'd1);
      send_ticks(6);
      drain_results();
   endtask

   // Hold the receiver off for a long stretch while items keep coming
   task automatic test_backpressure();
      set_profile(1, 1);
      req_steady        = 1'b1;
      long_hold_pending = 1'b1;
      send_item(ITEM_MOVE, 15'd3);
      send_ticks(24);
      req_steady = 1'b0;
      drain_results();
   endtask

   // Phases of random profiles, each a run of moves followed by ticks
   task automatic test_random_moves();
      int target;
      int phase;
      int phase_start;
      int phase_len;
      int min_period;
      int ramp_length;
      int magnitude;
      int ticks;
      int full_run;
      int k;
      logic [STEP_CNT_W-1:0] count;
      target = items_sent + RANDOM_ITEMS;
      phase  = 0;
      while (items_sent < target) begin
         // the first phases cover the register extremes, briefly
         case (phase)
            0: begin
               min_period = 255;
               ramp_length = 255;
            end
            1: begin
               min_period = 1;
               ramp_length = 0;
            end
            2: begin
               min_period = 255;
               ramp_length = 0;
            end
            default: begin
               min_period = $urandom_range(1, 3);
               ramp_length = $urandom_range(0, 4);
            end
         endcase
         phase_len   = (phase < 3) ? 25 : $urandom_range(120, 220);
         req_steady  = ($urandom_range(0, 3) == 0);
         rsp_steady  = ($urandom_range(0, 3) == 0);
         set_profile(min_period, ramp_length);
         phase_start = items_sent;
         while (items_sent - phase_start < phase_len && items_sent < target) begin
            if ($urandom_range(0, 99) < 85) begin
               if ($urandom_range(0, 9) == 0) begin
                  // any count at all, then a short look at the motion
                  count = STEP_CNT_W'($urandom_range(0, (1 << STEP_CNT_W) - 1));
                  ticks = $urandom_range(0, 20);
               end else begin
                  magnitude = $urandom_range(1, 5);
                  count = $urandom_range(0, 1) ? STEP_CNT_W'((1 << STEP_CNT_W) - magnitude)
                                               : STEP_CNT_W'(magnitude);
                  full_run = magnitude * TOGGLES_PER_STEP_DEF * (min_period + ramp_length + 1);
                  // most moves run to the end, some are cut short by the next one
                  if ($urandom_range(0, 3) != 0) begin
                     ticks = full_run + $urandom_range(0, 4);
                  end else begin
                     ticks = $urandom_range(0, full_run);
                  end
               end
               send_item(ITEM_MOVE, count);
               for (k = 0; k < ticks && items_sent - phase_start < phase_len; k++) begin
                  send_item(ITEM_TICK, STEP_CNT_W'($urandom));
               end
            end else if ($urandom_range(0, 1) == 0) begin
               send_ticks($urandom_range(1, 4));
            end else begin
               send_item(ITEM_MOVE, '0);
            end
         end
         drain_results();
         phase++;
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ITEM_TICK;
      csr_valid  = 1'b0;
      csr_index  = CSR_MIN_PERIOD;
      csr_data   = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_move_extremes();
      test_zero_period_restart();
      test_backpressure();
      test_random_moves();

      drain_results();
      repeat (5) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
